### rtl/core/assert_macros.svh
// Assertion macros shared by the SPI slave link RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define SSLK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included
`define SSLK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/core/sslk_pkg.sv
// Types, codes and helper functions for the SPI slave link engine
`default_nettype none

package sslk_pkg;

    // Item kinds carried in the input tuser field
    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_POP   = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK   = 2'd0;
    localparam logic [1:0] CFG_UNBLOCK = 2'd1;
    localparam logic [1:0] CFG_KEYWORD = 2'd2;

    localparam logic [7:0] BLOCK_RST   = 8'd1;
    localparam logic [7:0] UNBLOCK_RST = 8'd2;
    localparam logic [7:0] KEYWORD_RST = 8'd3;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int QCOUNT_W   = 5;

    // Send engine phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_KEY   = 3'd2,
        PH_INSTR = 3'd3,
        PH_LO    = 3'd4,
        PH_HI    = 3'd5
    } phase_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  rx_byte;
        logic        select_high;
        logic [7:0]  send_instr;
        logic [15:0] send_data;
        logic [15:0] send_timeout;
    } item_t;

    // Result fields produced by the control logic
    typedef struct packed {
        logic       tx_load;
        logic [7:0] tx_byte;
        logic       irq_active;
        logic       send_busy;
        logic       pop_valid;
        logic       push_dropped;
    } ctrl_res_t;

    // Requests from control to the FIFO
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        phase_t     phase;
        logic       load;
        logic [7:0] data;
    } adv_t;

    // One completed frame in an active send phase
    function automatic adv_t sslk_advance(input phase_t phase, input logic ignoring,
                                          input logic [7:0] keyword,
                                          input logic [7:0] instr,
                                          input logic [15:0] data);
        adv_t r;
        r.phase = phase;
        r.load  = 1'b0;
        r.data  = 8'd0;
        unique case (phase)
            PH_KEY:
            begin
                r.load = 1'b1;
                if (ignoring)
                begin
                    r.data = keyword;
                end
                else
                begin
                    r.data  = instr;
                    r.phase = PH_INSTR;
                end
            end
            PH_INSTR:
            begin
                r.load  = 1'b1;
                r.data  = data[7:0];
                r.phase = PH_LO;
            end
            PH_LO:
            begin
                r.load  = 1'b1;
                r.data  = data[15:8];
                r.phase = PH_HI;
            end
            PH_HI:
            begin
                r.phase = PH_IDLE;
            end
            default:
            begin
                r.phase = phase;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/spi_slave_link_engine.sv
// Top level: SPI slave link engine with input and result registers
// Each accepted request passes through the input register and then the result register.
// One request per cycle unless results stall; every request yields exactly one result.
// The critical path is the 32-bit elapsed-tick subtract and timeout compare.
// Reset (rst_n low, asynchronous) clears pointers, counters, flags and the send phase.
// FIFO storage is not cleared; the configuration registers return to 1, 2 and 3.
`default_nettype none
`include "assert_macros.svh"

module spi_slave_link_engine #(
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // rx_byte[7:0], select_high[8], send_instr[16:9], send_data[32:17],
    // send_timeout[48:33], zero fill[55:49]
    input  wire logic [55:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tx_load[0], tx_byte[8:1], irq_active[9], send_busy[10], pop_valid[11],
    // pop_byte[19:12], queued_count[24:20], push_dropped[25], zero fill[31:26]
    output logic [31:0]      m_axis_tdata
);
    import sslk_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                   in_valid_reg;
    item_t                  in_item_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                   advance;
    fifo_req_t              freq;
    fifo_stat_t             fstat;
    ctrl_res_t              cres;
    logic [CNT_W-1:0]       count_next;
    logic [7:0]             pop_data;
    logic [CNT_W+QCOUNT_W-1:0] count_ext;
    logic [QCOUNT_W-1:0]    queued_count;

    // Item moves to the result register when that register is free or drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.cmd          <= cmd_t'(s_axis_tuser);
            in_item_reg.rx_byte      <= s_axis_tdata[7:0];
            in_item_reg.select_high  <= s_axis_tdata[8];
            in_item_reg.send_instr   <= s_axis_tdata[16:9];
            in_item_reg.send_data    <= s_axis_tdata[32:17];
            in_item_reg.send_timeout <= s_axis_tdata[48:33];
        end
    end

    sslk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_item_reg),
        .fstat     (fstat),
        .freq      (freq),
        .res       (cres)
    );

    sslk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .req        (freq),
        .wr_data    (in_item_reg.rx_byte),
        .stat       (fstat),
        .count_next (count_next),
        .rd_data    (pop_data)
    );

    // Result packing
    assign count_ext    = {{QCOUNT_W{1'b0}}, count_next};
    assign queued_count = count_ext[QCOUNT_W-1:0];

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = cres.tx_load;
        out_data_next[8:1]   = cres.tx_byte;
        out_data_next[9]     = cres.irq_active;
        out_data_next[10]    = cres.send_busy;
        out_data_next[11]    = cres.pop_valid;
        out_data_next[19:12] = cres.pop_valid ? pop_data : 8'd0;
        out_data_next[24:20] = queued_count;
        out_data_next[25]    = cres.push_dropped;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SSLK_ASSERT(a_item_held, in_valid_reg && !advance |=> in_valid_reg,
                 "stalled request dropped from input register")

endmodule

`default_nettype wire

### rtl/core/sslk_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module sslk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/sslk_fifo.sv
// Receive FIFO: pointers, fill count, storage RAM and read bypass
`default_nettype none
`include "assert_macros.svh"

module sslk_fifo #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire sslk_pkg::fifo_req_t        req,
    input  wire logic [7:0]                 wr_data,
    output sslk_pkg::fifo_stat_t            stat,
    output logic      [$clog2(DEPTH+1)-1:0] count_next,
    output logic      [7:0]                 rd_data
);
    import sslk_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;
    logic             byp_reg, byp_next;
    logic [7:0]       byp_data_reg;
    logic [7:0]       ram_rdata;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    assign do_push = step && req.push && !stat.full;
    assign do_pop  = step && req.pop && !stat.empty;

    // Pointers wrap at the full depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            byp_reg    <= byp_next;
        end
    end

    // Head entry is prefetched; a write to it in the same cycle is bypassed
    assign byp_next = do_push && (wr_ptr_reg == rd_ptr_next);

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
    end

    sslk_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (wr_data),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    assign rd_data = byp_reg ? byp_data_reg : ram_rdata;

    `SSLK_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "fifo count beyond depth")
    `SSLK_ASSERT(a_count_push, do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1,
                 "fifo count did not follow push")

endmodule

`default_nettype wire

### rtl/core/sslk_ctrl.sv
// Frame decode, block flag, tick counter and send engine state machine
`default_nettype none
`include "assert_macros.svh"

module sslk_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 step,
    input  wire sslk_pkg::item_t      item,
    input  wire sslk_pkg::fifo_stat_t fstat,
    output sslk_pkg::fifo_req_t       freq,
    output sslk_pkg::ctrl_res_t       res
);
    import sslk_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        ign_reg, ign_next;
    logic        blocked_reg, blocked_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] start_reg, start_next;
    logic [7:0]  instr_reg, instr_next;
    logic [15:0] data_reg, data_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [7:0]  block_code_reg, unblock_code_reg, keyword_code_reg;
    logic        active;
    logic        active_end;
    logic [31:0] elapsed;
    adv_t        adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_code_reg   <= BLOCK_RST;
            unblock_code_reg <= UNBLOCK_RST;
            keyword_code_reg <= KEYWORD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK:   block_code_reg   <= cfg_wdata;
                CFG_UNBLOCK: unblock_code_reg <= cfg_wdata;
                CFG_KEYWORD: keyword_code_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ign_reg     <= 1'b0;
            blocked_reg <= 1'b0;
            tick_reg    <= '0;
            start_reg   <= '0;
            instr_reg   <= '0;
            data_reg    <= '0;
            tmo_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ign_reg     <= ign_next;
            blocked_reg <= blocked_next;
            tick_reg    <= tick_next;
            start_reg   <= start_next;
            instr_reg   <= instr_next;
            data_reg    <= data_next;
            tmo_reg     <= tmo_next;
        end
    end

    assign active = (phase_reg == PH_KEY) || (phase_reg == PH_INSTR) ||
                    (phase_reg == PH_LO) || (phase_reg == PH_HI);

    // Next state and result for the item in flight
    always_comb
    begin
        phase_next   = phase_reg;
        ign_next     = ign_reg;
        blocked_next = blocked_reg;
        tick_next    = tick_reg;
        start_next   = start_reg;
        instr_next   = instr_reg;
        data_next    = data_reg;
        tmo_next     = tmo_reg;
        freq         = '0;
        res          = '0;
        adv          = '0;
        active_end   = 1'b0;
        elapsed      = '0;

        if (step)
        begin
            unique case (item.cmd)
                CMD_FRAME:
                begin
                    if (item.select_high)
                    begin
                        ign_next = (item.rx_byte != 8'd0) && !blocked_reg && active;
                        if (active)
                        begin
                            adv = sslk_advance(phase_reg, ign_next, keyword_code_reg,
                                               instr_reg, data_reg);
                            phase_next  = adv.phase;
                            res.tx_load = adv.load;
                            res.tx_byte = adv.data;
                        end
                        else if (item.rx_byte == unblock_code_reg)
                        begin
                            blocked_next = 1'b0;
                        end
                        else
                        begin
                            if (item.rx_byte == block_code_reg)
                            begin
                                blocked_next = 1'b1;
                            end
                            freq.push        = 1'b1;
                            res.push_dropped = fstat.full;
                            res.tx_load      = 1'b1;
                            res.tx_byte      = 8'd0;
                        end
                    end
                end
                CMD_TICK:
                begin
                    tick_next = tick_reg + 32'd1;
                end
                CMD_SEND:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        instr_next = item.send_instr;
                        data_next  = item.send_data;
                        tmo_next   = item.send_timeout;
                        start_next = tick_reg;
                        phase_next = PH_WAIT;
                    end
                end
                CMD_POP:
                begin
                    freq.pop      = 1'b1;
                    res.pop_valid = !fstat.empty;
                end
            endcase

            // Waiting send starts once select is high and the link is free
            if (phase_next == PH_WAIT && item.select_high && !blocked_next)
            begin
                phase_next  = PH_KEY;
                res.tx_load = 1'b1;
                res.tx_byte = keyword_code_reg;
            end

            // Timeout: phases run through, data high last; ignored keyword holds
            active_end = (phase_next == PH_KEY) || (phase_next == PH_INSTR) ||
                         (phase_next == PH_LO) || (phase_next == PH_HI);
            elapsed    = tick_next - start_next;
            if (active_end && (elapsed > {16'd0, tmo_next}))
            begin
                if (phase_next == PH_HI)
                begin
                    phase_next = PH_IDLE;
                end
                else if (!(phase_next == PH_KEY && ign_next))
                begin
                    phase_next  = PH_IDLE;
                    res.tx_load = 1'b1;
                    res.tx_byte = data_next[15:8];
                end
            end
        end

        res.irq_active = (phase_next == PH_KEY) || (phase_next == PH_INSTR) ||
                         (phase_next == PH_LO) || (phase_next == PH_HI);
        res.send_busy  = (phase_next != PH_IDLE);
    end

    `SSLK_ASSERT(a_send_takes, step && item.cmd == CMD_SEND && phase_reg == PH_IDLE
                 |=> phase_reg != PH_IDLE, "send request from idle was lost")

endmodule

`default_nettype wire

### bench/spi_slave_link_check.sv
// Checker for the SPI slave link engine: tracks the request and result streams and compares
`default_nettype none

module spi_slave_link_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // rx_byte[7:0], select_high[8], send_instr[16:9], send_data[32:17], send_timeout[48:33]
    input  wire logic [55:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tx_load[0], tx_byte[8:1], irq_active[9], send_busy[10], pop_valid[11],
    // pop_byte[19:12], queued_count[24:20], push_dropped[25]
    input  wire logic [31:0] m_axis_tdata,
    output int               pending,
    output int               mismatch_total
);
    timeunit 1ns;
    timeprecision 1ps;
    import sslk_pkg::*;

    localparam int DEPTH = 16;

    // Field order gives the same bit layout as m_axis_tdata[25:0]
    typedef struct packed {
        logic       push_dropped;
        logic [4:0] queued_count;
        logic [7:0] pop_byte;
        logic       pop_valid;
        logic       send_busy;
        logic       irq_active;
        logic [7:0] tx_byte;
        logic       tx_load;
    } link_result_t;

    // Mirror of the engine state
    logic [7:0]   block_code_q;
    logic [7:0]   unblock_code_q;
    logic [7:0]   keyword_code_q;
    logic [7:0]   rx_fifo [DEPTH];
    logic [3:0]   rd_ptr;
    logic [3:0]   wr_ptr;
    logic [4:0]   fill;
    logic         blocked;
    logic         ignoring;
    phase_t       phase;
    logic [31:0]  ticks;
    logic [31:0]  send_start;
    logic [7:0]   send_instr_q;
    logic [15:0]  send_data_q;
    logic [15:0]  send_timeout_q;
    logic         loaded;
    logic [7:0]   loaded_byte;

    link_result_t expected_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_total++;
    endtask

    function automatic logic sending();
        return phase >= PH_KEY && phase <= PH_HI;
    endfunction

    // One finished frame while the send engine is active
    function automatic void advance_send_phase();
        case (phase)
            PH_KEY:
            begin
                loaded = 1'b1;
                if (ignoring)
                begin
                    loaded_byte = keyword_code_q;
                end
                else
                begin
                    loaded_byte = send_instr_q;
                    phase       = PH_INSTR;
                end
            end
            PH_INSTR:
            begin
                loaded      = 1'b1;
                loaded_byte = send_data_q[7:0];
                phase       = PH_LO;
            end
            PH_LO:
            begin
                loaded      = 1'b1;
                loaded_byte = send_data_q[15:8];
                phase       = PH_HI;
            end
            PH_HI:
            begin
                phase = PH_IDLE;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Apply one request to the mirror and return the result it should produce
    function automatic link_result_t predict_result(input item_t it);
        link_result_t r;
        logic         active;
        r           = '0;
        loaded      = 1'b0;
        loaded_byte = 8'd0;
        case (it.cmd)
            CMD_FRAME:
            begin
                if (it.select_high)
                begin
                    active   = sending();
                    ignoring = (it.rx_byte != 8'd0) && !blocked && active;
                    if (active)
                    begin
                        advance_send_phase();
                    end
                    else if (it.rx_byte == unblock_code_q)
                    begin
                        blocked = 1'b0;
                    end
                    else
                    begin
                        if (it.rx_byte == block_code_q)
                        begin
                            blocked = 1'b1;
                        end
                        if (fill >= DEPTH)
                        begin
                            r.push_dropped = 1'b1;
                        end
                        else
                        begin
                            rx_fifo[wr_ptr] = it.rx_byte;
                            wr_ptr++;
                            fill++;
                        end
                        loaded      = 1'b1;
                        loaded_byte = 8'd0;
                    end
                end
            end
            CMD_TICK:
            begin
                ticks++;
            end
            CMD_SEND:
            begin
                if (phase == PH_IDLE)
                begin
                    send_instr_q   = it.send_instr;
                    send_data_q    = it.send_data;
                    send_timeout_q = it.send_timeout;
                    send_start     = ticks;
                    phase          = PH_WAIT;
                end
            end
            default:
            begin
                if (fill != 5'd0)
                begin
                    r.pop_valid = 1'b1;
                    r.pop_byte  = rx_fifo[rd_ptr];
                    rd_ptr++;
                    fill--;
                end
            end
        endcase

        // A waiting send starts once select is high and the link is free
        if (phase == PH_WAIT && it.select_high && !blocked)
        begin
            phase       = PH_KEY;
            loaded      = 1'b1;
            loaded_byte = keyword_code_q;
        end

        // Timeout: flush the remaining phases, except a keyword phase the master ignores
        if (sending() && (ticks - send_start) > {16'd0, send_timeout_q})
        begin
            for (int step = 0; step < 5; step++)
            begin
                if (phase == PH_IDLE || (phase == PH_KEY && ignoring))
                begin
                    break;
                end
                advance_send_phase();
            end
        end

        r.tx_load      = loaded;
        r.tx_byte      = loaded ? loaded_byte : 8'd0;
        r.irq_active   = sending();
        r.send_busy    = phase != PH_IDLE;
        r.queued_count = fill;
        return r;
    endfunction

    // Results are checked before new requests so a stray result is never matched early
    always @(posedge clk or negedge rst_n)
    begin
        link_result_t got;
        link_result_t want;
        item_t        it;
        if (!rst_n)
        begin
            block_code_q   = BLOCK_RST;
            unblock_code_q = UNBLOCK_RST;
            keyword_code_q = KEYWORD_RST;
            rd_ptr         = '0;
            wr_ptr         = '0;
            fill           = '0;
            blocked        = 1'b0;
            ignoring       = 1'b0;
            phase          = PH_IDLE;
            ticks          = '0;
            send_start     = '0;
            send_instr_q   = '0;
            send_data_q    = '0;
            send_timeout_q = '0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BLOCK:   block_code_q   = cfg_wdata;
                    CFG_UNBLOCK: unblock_code_q = cfg_wdata;
                    CFG_KEYWORD: keyword_code_q = cfg_wdata;
                    default:     ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = link_result_t'(m_axis_tdata[25:0]);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_axis_tdata, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.tx_load !== want.tx_load)
                        report_mismatch("tx_load", 32'(got.tx_load), 32'(want.tx_load));
                    if (got.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
                    if (got.irq_active !== want.irq_active)
                        report_mismatch("irq_active", 32'(got.irq_active),
                                        32'(want.irq_active));
                    if (got.send_busy !== want.send_busy)
                        report_mismatch("send_busy", 32'(got.send_busy),
                                        32'(want.send_busy));
                    if (got.pop_valid !== want.pop_valid)
                        report_mismatch("pop_valid", 32'(got.pop_valid),
                                        32'(want.pop_valid));
                    if (got.pop_byte !== want.pop_byte)
                        report_mismatch("pop_byte", 32'(got.pop_byte), 32'(want.pop_byte));
                    if (got.queued_count !== want.queued_count)
                        report_mismatch("queued_count", 32'(got.queued_count),
                                        32'(want.queued_count));
                    if (got.push_dropped !== want.push_dropped)
                        report_mismatch("push_dropped", 32'(got.push_dropped),
                                        32'(want.push_dropped));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                it.cmd          = cmd_t'(s_axis_tuser);
                it.rx_byte      = s_axis_tdata[7:0];
                it.select_high  = s_axis_tdata[8];
                it.send_instr   = s_axis_tdata[16:9];
                it.send_data    = s_axis_tdata[32:17];
                it.send_timeout = s_axis_tdata[48:33];
                expected_results.push_back(predict_result(it));
            end

            pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

### bench/tb_spi_slave_link_engine.sv
// Testbench top for the SPI slave link engine: clock, reset, stimulus and verdict
`default_nettype none

module tb_spi_slave_link_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import sslk_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // rx_byte[7:0], select_high[8], send_instr[16:9], send_data[32:17],
    // send_timeout[48:33], zero fill[55:49]
    logic [55:0] s_axis_tdata;
    // cmd[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tx_load[0], tx_byte[8:1], irq_active[9], send_busy[10], pop_valid[11],
    // pop_byte[19:12], queued_count[24:20], push_dropped[25], zero fill[31:26]
    logic [31:0] m_axis_tdata;

    int          pending;
    int          mismatch_total;
    int          sender_idle_pct;
    int          stall_pct;
    int          kind_count [4];
    logic [7:0]  block_val;
    logic [7:0]  unblock_val;
    logic [7:0]  keyword_val;

    spi_slave_link_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spi_slave_link_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .pending        (pending),
        .mismatch_total (mismatch_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Present one request and hold it until the engine takes it
    task automatic issue_request(input cmd_t kind, input logic [7:0] rx, input logic sel,
                                 input logic [7:0] instr, input logic [15:0] data,
                                 input logic [15:0] timeout_ms);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, timeout_ms, data, instr, sel, rx};
        s_axis_tuser  <= kind;
        kind_count[kind]++;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result, then let the pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] blk, input logic [7:0] unblk,
                                  input logic [7:0] key);
        block_val   = blk;
        unblock_val = unblk;
        keyword_val = key;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLOCK;
        cfg_wdata <= blk;
        @(posedge clk);
        cfg_index <= CFG_UNBLOCK;
        cfg_wdata <= unblk;
        @(posedge clk);
        cfg_index <= CFG_KEYWORD;
        cfg_wdata <= key;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic biased toward codes that drive the send engine and the FIFO
    task automatic run_random(input int count, input int idle_pct, input int stall);
        int          pop_weight;
        int          roll;
        int          pick;
        logic [7:0]  rx;
        logic [15:0] timeout_ms;
        cmd_t        kind;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        pop_weight      = 20;
        for (int n = 0; n < count; n++)
        begin
            // Pop rate drifts so the FIFO both overflows and runs dry
            if (n % 40 == 0)
            begin
                pop_weight = $urandom_range(60, 5);
            end
            roll = $urandom_range(99);
            if (roll < pop_weight)
                kind = CMD_POP;
            else if (roll < pop_weight + 12)
                kind = CMD_TICK;
            else if (roll < pop_weight + 22)
                kind = CMD_SEND;
            else
                kind = CMD_FRAME;

            pick = $urandom_range(99);
            if (pick < 35)
                rx = 8'd0;
            else if (pick < 45)
                rx = block_val;
            else if (pick < 60)
                rx = unblock_val;
            else if (pick < 65)
                rx = keyword_val;
            else
                rx = 8'($urandom);

            timeout_ms = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6));
            issue_request(kind, rx, ($urandom_range(9) != 0), 8'($urandom), 16'($urandom),
                          timeout_ms);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_BLOCK;
        cfg_wdata       = 8'd0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = CMD_FRAME;
        sender_idle_pct = 17;
        stall_pct       = 79;
        block_val       = BLOCK_RST;
        unblock_val     = UNBLOCK_RST;
        keyword_val     = KEYWORD_RST;
        foreach (kind_count[k]) kind_count[k] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset register values
        issue_request(CMD_POP,   8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // empty pop
        issue_request(CMD_FRAME, 8'h55, 1'b0, 8'h00, 16'h0000, 16'h0000); // select low
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000);
        issue_request(CMD_FRAME, 8'hFF, 1'b1, 8'h00, 16'h0000, 16'h0000);
        issue_request(CMD_POP,   8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000);
        issue_request(CMD_FRAME, BLOCK_RST, 1'b1, 8'h00, 16'h0000, 16'h0000); // block
        issue_request(CMD_SEND,  8'h00, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF); // held by block
        issue_request(CMD_TICK,  8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000);
        issue_request(CMD_FRAME, UNBLOCK_RST, 1'b1, 8'h00, 16'h0000, 16'h0000); // starts
        issue_request(CMD_FRAME, 8'h5A, 1'b1, 8'h00, 16'h0000, 16'h0000); // master ignoring
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // instruction
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // data low
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // data high
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // send done
        issue_request(CMD_SEND,  8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // zero timeout
        issue_request(CMD_TICK,  8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // flush to idle
        issue_request(CMD_SEND,  8'h00, 1'b1, 8'hA5, 16'h1234, 16'h0000);
        issue_request(CMD_FRAME, 8'h77, 1'b1, 8'h00, 16'h0000, 16'h0000); // ignoring again
        issue_request(CMD_TICK,  8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // stuck on keyword
        issue_request(CMD_FRAME, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // then flushes
        issue_request(CMD_SEND,  8'h00, 1'b0, 8'h3C, 16'hBEEF, 16'h0002); // select low: waits
        issue_request(CMD_SEND,  8'h00, 1'b0, 8'hC3, 16'h0101, 16'h0005); // busy: dropped
        issue_request(CMD_POP,   8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000); // pop and start
        wait_drained();

        // Two extreme and one random register set under three flow-control patterns
        apply_settings(8'h00, 8'hFF, 8'hFF);
        run_random(500, 17, 79);
        wait_drained();
        apply_settings(8'hFF, 8'h00, 8'h00);
        run_random(500, 79, 17);
        wait_drained();
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(500, 0, 0);
        wait_drained();

        $display("Covered %0d frame ends, %0d ticks, %0d send requests and %0d pops",
                 kind_count[CMD_FRAME], kind_count[CMD_TICK], kind_count[CMD_SEND],
                 kind_count[CMD_POP]);
        $display("Reset, two extreme and one random register set; %0d mismatches",
                 mismatch_total);
        if (mismatch_total == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
